/* rtl/core/phac_pkg.sv */
// Shared types, constants and helper functions for the position-hold attitude command block.
// Holds the tanh table builder that the response lanes evaluate at elaboration.
// No dependencies.
package phac_pkg;

  // data widths
  localparam int unsigned DATA_W         = 16;
  localparam int unsigned CFG_INDEX_W    = 2;
  localparam int unsigned SPAN_SHIFT     = 18;
  localparam int unsigned LANE_STAGES    = 4;
  localparam int unsigned PIPE_STAGES    = 6;

  // tanh table sizing
  localparam int unsigned TANH_DEPTH_DEFAULT = 64;
  localparam int unsigned TANH_DEPTH_MAX     = 1024;
  localparam int unsigned EXP_TERMS          = 24;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SLOPE     = 2'd1;

  // configuration reset values
  localparam logic [DATA_W-1:0] AMPLITUDE_RESET = 16'd1280;
  localparam logic [DATA_W-1:0] SLOPE_RESET     = 16'd640;

  typedef logic [DATA_W-1:0] tanh_rom_t [TANH_DEPTH_MAX+1];

  // per-stage advance strobes for a response lane, bit 0 loads the first lane stage
  typedef struct packed {
    logic [LANE_STAGES-1:0] adv;
  } lane_ctrl_t;

  // data that travels beside the lanes towards the merge stage
  typedef struct packed {
    logic signed [DATA_W-1:0] avoid_roll;
    logic signed [DATA_W-1:0] avoid_pitch;
    logic signed [DATA_W-1:0] herr;
    logic                     latched;
  } side_t;

  // saturate a 17-bit signed sum to 16 bits
  function automatic logic signed [DATA_W-1:0] sat16(input logic signed [DATA_W:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 17'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -17'sd32768) begin
      r = -16'sh8000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // unsigned 64-bit quotient by shift and subtract, evaluated at elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // tanh(4k/depth) in unsigned Q0.16, built by Q30 integer arithmetic at elaboration
  function automatic tanh_rom_t build_tanh(input int unsigned depth);
    tanh_rom_t   rom;
    logic [63:0] q30;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] ts;
    logic [63:0] t;
    logic [63:0] q;
    rom  = '{default: '0};
    q30  = 64'd1 << 30;
    x    = udiv64(64'd8 << 30, 64'(depth));
    term = q30;
    e    = q30;
    for (int n = 1; n < EXP_TERMS; n++) begin
      term = udiv64((term * x) >> 30, 64'(n));
      e    = e + term;
    end
    ts = udiv64((e - q30) << 30, e + q30);
    t  = '0;
    for (int k = 0; k <= TANH_DEPTH_MAX; k++) begin
      if (k <= int'(depth)) begin
        q      = (t + (64'd1 << 13)) >> 14;
        rom[k] = (q > 64'd65535) ? 16'hffff : q[15:0];
        t      = udiv64((t + ts) << 30, q30 + ((t * ts) >> 30));
      end
    end
    return rom;
  endfunction

endpackage

/* rtl/core/phac_lane.sv */
// One response lane: offset magnitude times slope, interpolated tanh, scaled by amplitude.
// Four register stages, each advanced by its own strobe from the top level.
// Depends on phac_pkg.
module phac_lane #(
  parameter int unsigned TANH_TABLE_DEPTH = phac_pkg::TANH_DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  phac_pkg::lane_ctrl_t               ctrl,
  input  logic signed [phac_pkg::DATA_W-1:0] offset,
  input  logic        [phac_pkg::DATA_W-1:0] amplitude,
  input  logic        [phac_pkg::DATA_W-1:0] slope,
  output logic signed [phac_pkg::DATA_W-1:0] resp
);

  localparam int unsigned DW    = phac_pkg::DATA_W;
  localparam int unsigned SPAN  = phac_pkg::SPAN_SHIFT;
  localparam int unsigned IDX_W = $clog2(TANH_TABLE_DEPTH + 1);
  localparam int unsigned POS_W = SPAN + IDX_W;
  localparam phac_pkg::tanh_rom_t TANH_ROM = phac_pkg::build_tanh(TANH_TABLE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TANH_TABLE_DEPTH);

  // stage registers
  logic            big;
  logic [SPAN-1:0] mag_lo;
  logic            neg2;
  logic [DW-1:0]   lo;
  logic [DW-1:0]   hi;
  logic [SPAN-1:0] frac;
  logic            neg3;
  logic [DW-1:0]   th;
  logic            neg4;

  // magnitude of the offset and its product with the slope
  logic signed [DW:0] off_ext;
  logic        [DW:0] off_abs;
  logic      [2*DW-1:0] mag;
  assign off_ext = {offset[DW-1], offset};
  assign off_abs = offset[DW-1] ? (DW+1)'(-off_ext) : (DW+1)'(off_ext);
  assign mag     = off_abs[DW-1:0] * slope;

  always_ff @(posedge clk) begin
    if (ctrl.adv[0]) begin
      big    <= |mag[2*DW-1:SPAN];
      mag_lo <= mag[SPAN-1:0];
      neg2   <= offset[DW-1];
    end
  end

  // table position, index and fraction
  logic [POS_W-1:0] pos;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_hi;
  assign pos    = POS_W'(mag_lo) * POS_W'(TANH_TABLE_DEPTH);
  assign idx    = pos[POS_W-1:SPAN];
  assign idx_hi = idx + IDX_W'(1);

  always_ff @(posedge clk) begin
    if (ctrl.adv[1]) begin
      if (big) begin
        lo   <= TANH_ROM[LAST_IDX];
        hi   <= TANH_ROM[LAST_IDX];
        frac <= '0;
      end else begin
        lo   <= TANH_ROM[idx];
        hi   <= TANH_ROM[idx_hi];
        frac <= pos[SPAN-1:0];
      end
      neg3 <= neg2;
    end
  end

  // linear interpolation between neighbouring entries
  logic                 rising;
  logic [DW-1:0]        diff;
  logic [DW+SPAN-1:0]   dprod;
  logic [DW-1:0]        step;
  assign rising = (hi >= lo);
  assign diff   = rising ? (hi - lo) : (lo - hi);
  assign dprod  = (DW+SPAN)'(diff) * (DW+SPAN)'(frac);
  assign step   = dprod[DW+SPAN-1:SPAN];

  always_ff @(posedge clk) begin
    if (ctrl.adv[2]) begin
      th   <= rising ? (lo + step) : (lo - step);
      neg4 <= neg3;
    end
  end

  // amplitude scaling with rounding, clamp and sign
  logic [2*DW-1:0]    aprod;
  logic [2*DW:0]      rsum;
  logic [DW:0]        rq;
  logic [DW-2:0]      rclip;
  logic signed [DW-1:0] rpos;
  assign aprod = amplitude * th;
  assign rsum  = {1'b0, aprod} + (2*DW+1)'(33'd32768);
  assign rq    = rsum[2*DW:DW];
  assign rclip = (rq > (DW+1)'(17'd32767)) ? {(DW-1){1'b1}} : rq[DW-2:0];
  assign rpos  = $signed({1'b0, rclip});

  always_ff @(posedge clk) begin
    if (ctrl.adv[3]) begin
      resp <= neg4 ? -rpos : rpos;
    end
  end

endmodule

/* rtl/core/phac_merge.sv */
// Merge stage: adds each lane response to its avoidance command, except on the latch item, and holds the result.
// This is the output register of the block.
// Depends on phac_pkg.
module phac_merge (
  input  logic                               clk,
  input  logic                               load,
  input  phac_pkg::side_t                    side,
  input  logic signed [phac_pkg::DATA_W-1:0] resp_roll,
  input  logic signed [phac_pkg::DATA_W-1:0] resp_pitch,
  output logic signed [phac_pkg::DATA_W-1:0] roll_command,
  output logic signed [phac_pkg::DATA_W-1:0] pitch_command,
  output logic signed [phac_pkg::DATA_W-1:0] heading_error,
  output logic                               target_latched
);

  localparam int unsigned DW = phac_pkg::DATA_W;

  // saturated sums
  logic signed [DW-1:0] roll_sum;
  logic signed [DW-1:0] pitch_sum;
  assign roll_sum  = phac_pkg::sat16((DW+1)'(side.avoid_roll) + (DW+1)'(resp_roll));
  assign pitch_sum = phac_pkg::sat16((DW+1)'(side.avoid_pitch) + (DW+1)'(resp_pitch));

  // output register; the latch item passes the avoidance commands through
  always_ff @(posedge clk) begin
    if (load) begin
      roll_command   <= side.latched ? side.avoid_roll  : roll_sum;
      pitch_command  <= side.latched ? side.avoid_pitch : pitch_sum;
      heading_error  <= side.herr;
      target_latched <= side.latched;
    end
  end

endmodule

/* rtl/core/position_hold_attitude_command.sv */
// Position-hold attitude command: top level with hold target, offset stage,
// two response lanes (pitch from x, roll from y) and the merge stage.
// Depends on phac_pkg, phac_lane and phac_merge.
//
// Usage:
//   Input channel in_valid/in_stall carries avoid_roll, avoid_pitch, pos_x,
//   pos_y and heading; a transaction completes when in_valid is high and
//   in_stall is low. Each transaction yields exactly one result on the
//   out_valid/out_stall channel (roll_command, pitch_command, heading_error,
//   target_latched).
//   Pipeline: six register stages (offset stage, four lane stages for slope
//   multiply, table read, interpolation multiply and amplitude multiply, and
//   the merge register). One item is taken every cycle while in_stall is
//   low; each stage holds while the stage after it is full and stalled, so
//   in_stall rises only once the whole pipeline is backed up behind a
//   stalled output.
//   Configuration: cfg_valid/cfg_ready write cfg_data to register cfg_index
//   (0 amplitude, 1 slope); cfg_ready is always high, other indexes are ignored.
//   Reset (rst, synchronous) empties the pipeline, restores the register
//   defaults and rearms the target, so the next transaction latches it.
module position_hold_attitude_command #(
  parameter int unsigned TANH_TABLE_DEPTH = phac_pkg::TANH_DEPTH_DEFAULT
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [phac_pkg::DATA_W-1:0]      avoid_roll,
  input  logic signed [phac_pkg::DATA_W-1:0]      avoid_pitch,
  input  logic signed [phac_pkg::DATA_W-1:0]      pos_x,
  input  logic signed [phac_pkg::DATA_W-1:0]      pos_y,
  input  logic signed [phac_pkg::DATA_W-1:0]      heading,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [phac_pkg::DATA_W-1:0]      roll_command,
  output logic signed [phac_pkg::DATA_W-1:0]      pitch_command,
  output logic signed [phac_pkg::DATA_W-1:0]      heading_error,
  output logic                                    target_latched,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic        [phac_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic        [phac_pkg::DATA_W-1:0]      cfg_data
);

  localparam int unsigned DW = phac_pkg::DATA_W;
  localparam int unsigned NS = phac_pkg::PIPE_STAGES;
  localparam int unsigned LS = phac_pkg::LANE_STAGES;

  // configuration registers
  logic [DW-1:0] amplitude;
  logic [DW-1:0] slope;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude <= phac_pkg::AMPLITUDE_RESET;
      slope     <= phac_pkg::SLOPE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        phac_pkg::REG_AMPLITUDE: amplitude <= cfg_data;
        phac_pkg::REG_SLOPE:     slope     <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline occupancy and per-stage ready
  logic [NS:1] valid;
  logic [NS:1] ready;
  logic        accept;

  always_comb begin
    ready[NS] = !valid[NS] || !out_stall;
    for (int k = NS - 1; k >= 1; k--) begin
      ready[k] = !valid[k] || ready[k+1];
    end
  end

  assign accept    = in_valid && ready[1];
  assign in_stall  = !ready[1];
  assign out_valid = valid[NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ready[1]) begin
        valid[1] <= in_valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (ready[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  // hold target, latched by the first transaction after reset
  logic                 awaiting;
  logic signed [DW-1:0] target_x;
  logic signed [DW-1:0] target_y;
  logic signed [DW-1:0] target_heading;

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting       <= 1'b1;
      target_x       <= '0;
      target_y       <= '0;
      target_heading <= '0;
    end else if (accept && awaiting) begin
      awaiting       <= 1'b0;
      target_x       <= pos_x;
      target_y       <= pos_y;
      target_heading <= heading;
    end
  end

  // offset stage: saturated differences against the target
  logic signed [DW-1:0] dx_next;
  logic signed [DW-1:0] dy_next;
  logic signed [DW-1:0] herr_next;
  assign dx_next   = phac_pkg::sat16((DW+1)'(pos_x) - (DW+1)'(target_x));
  assign dy_next   = phac_pkg::sat16((DW+1)'(pos_y) - (DW+1)'(target_y));
  assign herr_next = phac_pkg::sat16((DW+1)'(heading) - (DW+1)'(target_heading));

  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  phac_pkg::side_t      side [1:NS-1];

  // offset registers, then side data following the lane stages
  always_ff @(posedge clk) begin
    if (ready[1]) begin
      dx                  <= awaiting ? '0 : dx_next;
      dy                  <= awaiting ? '0 : dy_next;
      side[1].avoid_roll  <= avoid_roll;
      side[1].avoid_pitch <= avoid_pitch;
      side[1].herr        <= awaiting ? '0 : herr_next;
      side[1].latched     <= awaiting;
    end
    for (int k = 2; k <= NS - 1; k++) begin
      if (ready[k]) begin
        side[k] <= side[k-1];
      end
    end
  end

  // response lanes
  phac_pkg::lane_ctrl_t lane_ctrl;
  assign lane_ctrl.adv = ready[LS+1:2];

  logic signed [DW-1:0] resp_pitch;
  logic signed [DW-1:0] resp_roll;

  phac_lane #(
    .TANH_TABLE_DEPTH(TANH_TABLE_DEPTH)
  ) u_lane_x (
    .clk       (clk),
    .ctrl      (lane_ctrl),
    .offset    (dx),
    .amplitude (amplitude),
    .slope     (slope),
    .resp      (resp_pitch)
  );

  phac_lane #(
    .TANH_TABLE_DEPTH(TANH_TABLE_DEPTH)
  ) u_lane_y (
    .clk       (clk),
    .ctrl      (lane_ctrl),
    .offset    (dy),
    .amplitude (amplitude),
    .slope     (slope),
    .resp      (resp_roll)
  );

  // merge stage and output register
  phac_merge u_merge (
    .clk            (clk),
    .load           (ready[NS]),
    .side           (side[NS-1]),
    .resp_roll      (resp_roll),
    .resp_pitch     (resp_pitch),
    .roll_command   (roll_command),
    .pitch_command  (pitch_command),
    .heading_error  (heading_error),
    .target_latched (target_latched)
  );

`ifndef SYNTHESIS
  // the first transaction after reset clears the target request
  a_latch_once: assert property (@(posedge clk) disable iff (rst)
    accept && awaiting |=> !awaiting)
    else $error("target request not cleared after latch transaction");

  // the target is never rearmed without reset
  a_no_rearm: assert property (@(posedge clk) disable iff (rst)
    !awaiting |=> !awaiting)
    else $error("target request rearmed without reset");

  // a latch result carries zero heading error
  a_latch_zero_herr: assert property (@(posedge clk) disable iff (rst)
    out_valid && target_latched |-> heading_error == '0)
    else $error("latch result with non-zero heading error");

  // input is held off only when the first and last stages are occupied and the output is stalled
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> valid[1] && valid[NS] && out_stall)
    else $error("input stalled with room in the pipeline");
`endif

endmodule
